>>> design/braille_cell_encoder_assert.svh
// Assertion macros for the braille cell encoder RTL, included by bce_fifo.
// No dependencies; include by bare file name inside a module body.
`ifndef BRAILLE_CELL_ENCODER_ASSERT_SVH
`define BRAILLE_CELL_ENCODER_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BCE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define BCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/bce_pkg.sv
// Package for the braille cell encoder: constants, queue entry and status types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bce_pkg;

  localparam int unsigned NumPix = 8;

  typedef logic [23:0] pixel_t;
  typedef logic [7:0]  luma_t;

  // Luma weights, scaled by 1000
  localparam logic [17:0] LumaR = 18'd213;
  localparam logic [17:0] LumaG = 18'd715;
  localparam logic [17:0] LumaB = 18'd72;

  // Divide by 1000 as multiply by ceil(2^28 / 1000), exact for sums up to 255000
  localparam int unsigned   LumaShift = 28;
  localparam int unsigned   ProdW     = 37;
  localparam logic [18:0]   LumaRecip = 19'd268436;

  localparam logic [7:0] FloorReset   = 8'd25;
  localparam logic [7:0] GlyphMidBase = 8'hA0;
  localparam logic [7:0] GlyphLowBase = 8'h80;
  localparam logic [5:0] GlyphLowMask = 6'h3F;

  // Bit of the dot pattern that each pixel drives (Unicode dot order)
  localparam logic [2:0] DotPos [NumPix] = '{3'd0, 3'd3, 3'd1, 3'd4,
                                             3'd2, 3'd5, 3'd6, 3'd7};

  // Queue between classifier and output stage
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    logic [7:0] dot_pattern;
    pixel_t     fore;
    pixel_t     back;
    logic       end_of_row;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

>>> design/braille_cell_encoder.sv
// Top level of the braille cell encoder: config register, front pipeline, queue, output.
// Depends on bce_pkg, bce_front, bce_fifo and bce_back.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | in_valid_i / in_ready_o | pixel_0_i..pixel_7_i, valid_mask_i, end_of_row_i
//  out     | out_valid_o / out_ready_i | dot_pattern_o, glyph bytes, colours, flags
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_data_i (contrast floor)
//
// One cell per clock while the output is not stalled; a cell passes through the four front
// stages (the first loads at the accepting edge), the queue write and the output load
// before it reaches the output register.
// Reset clears the queue and row colours (black) and sets the contrast floor to 25.
// A stalled output fills the four-entry queue; the front then holds and drops ready.
`timescale 1ns / 1ps

module braille_cell_encoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [23:0]         pixel_0_i,
  input  logic [23:0]         pixel_1_i,
  input  logic [23:0]         pixel_2_i,
  input  logic [23:0]         pixel_3_i,
  input  logic [23:0]         pixel_4_i,
  input  logic [23:0]         pixel_5_i,
  input  logic [23:0]         pixel_6_i,
  input  logic [23:0]         pixel_7_i,
  input  logic [7:0]          valid_mask_i,
  input  logic                end_of_row_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          dot_pattern_o,
  output logic [7:0]          glyph_mid_byte_o,
  output logic [7:0]          glyph_low_byte_o,
  output logic [23:0]         fore_color_o,
  output logic [23:0]         back_color_o,
  output logic                fore_changed_o,
  output logic                back_changed_o,
  output logic                row_done_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);
  import bce_pkg::*;

  logic [7:0] floor_q;
  pixel_t     pix [NumPix];
  logic       push, pop;
  q_entry_t   push_data, pop_data;
  q_status_t  q_status;

  // Hold the contrast floor
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FloorReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      floor_q <= cfg_data_i;
    end
  end

  assign pix[0] = pixel_0_i;
  assign pix[1] = pixel_1_i;
  assign pix[2] = pixel_2_i;
  assign pix[3] = pixel_3_i;
  assign pix[4] = pixel_4_i;
  assign pix[5] = pixel_5_i;
  assign pix[6] = pixel_6_i;
  assign pix[7] = pixel_7_i;

  bce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pix_i       (pix),
    .mask_i      (valid_mask_i),
    .eor_i       (end_of_row_i),
    .floor_i     (floor_q),
    .q_full_i    (q_status.full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  bce_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  bce_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_status_i       (q_status),
    .q_data_i         (pop_data),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .dot_pattern_o    (dot_pattern_o),
    .glyph_mid_byte_o (glyph_mid_byte_o),
    .glyph_low_byte_o (glyph_low_byte_o),
    .fore_color_o     (fore_color_o),
    .back_color_o     (back_color_o),
    .fore_changed_o   (fore_changed_o),
    .back_changed_o   (back_changed_o),
    .row_done_o       (row_done_o)
  );

endmodule

>>> design/bce_fifo.sv
// Short queue of classified cells between the front pipeline and the output stage.
// Depends on bce_pkg and braille_cell_encoder_assert.svh.
`timescale 1ns / 1ps

module bce_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bce_pkg::q_entry_t  push_data_i,
  input  logic               pop_i,
  output bce_pkg::q_entry_t  pop_data_o,
  output bce_pkg::q_status_t status_o
);
  import bce_pkg::*;
  `include "braille_cell_encoder_assert.svh"

  q_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  // Write the entry store
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      count_q <= count_d;
    end
  end

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QCntW'(QDepth));

  `BCE_ASSERT_IMPL(a_no_overfill, clk_i, rst_ni, 1'b1, count_q <= QCntW'(QDepth), "queue overfilled")
  `BCE_ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, pop_i, count_q != '0, "pop from empty queue")
  `BCE_ASSERT_IMPL(a_no_push_full, clk_i, rst_ni, push_i, count_q != QCntW'(QDepth), "push into full queue")
  `BCE_ASSERT_NEXT(a_pop_drains, clk_i, rst_ni, pop_i && !push_i, count_q == $past(count_q) - QCntW'(1), "pop did not drain")

endmodule

>>> design/bce_front.sv
// Front pipeline: luma per pixel, darkest/brightest search, dot classification.
// Depends on bce_pkg; feeds bce_fifo.
`timescale 1ns / 1ps

module bce_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bce_pkg::pixel_t    pix_i [bce_pkg::NumPix],
  input  logic [7:0]         mask_i,
  input  logic               eor_i,
  input  logic [7:0]         floor_i,
  input  logic               q_full_i,
  output logic               push_o,
  output bce_pkg::q_entry_t  push_data_o
);
  import bce_pkg::*;

  typedef struct packed {
    logic   v;
    luma_t  l;
    pixel_t px;
  } cand_t;

  // Keep the earlier candidate unless the later one is strictly darker
  function automatic cand_t pick_min(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (!a.v || (b.v && (b.l < a.l))) r = b;
    return r;
  endfunction

  // Keep the earlier candidate unless the later one is strictly brighter
  function automatic cand_t pick_max(input cand_t a, input cand_t b);
    cand_t r;
    r = a;
    if (!a.v || (b.v && (b.l > a.l))) r = b;
    return r;
  endfunction

  logic adv;

  logic        a_v_q;
  logic [17:0] a_sum_q [NumPix];
  pixel_t      a_px_q  [NumPix];
  logic [7:0]  a_mask_q;
  logic        a_eor_q;

  logic        b_v_q;
  luma_t       b_luma_q [NumPix];
  pixel_t      b_px_q   [NumPix];
  logic [7:0]  b_mask_q;
  logic        b_eor_q;

  logic        c_v_q;
  luma_t       c_luma_q [NumPix];
  logic [7:0]  c_mask_q;
  logic        c_any_q;
  luma_t       c_min_q, c_max_q;
  pixel_t      c_dark_q, c_bright_q;
  logic        c_eor_q;

  logic        d_v_q;
  q_entry_t    d_entry_q;

  logic [17:0]      sum_d  [NumPix];
  logic [ProdW-1:0] prod_d [NumPix];
  luma_t            luma_d [NumPix];
  cand_t            leaf [NumPix];
  cand_t            mn1 [4], mx1 [4];
  cand_t            mn2 [2], mx2 [2];
  cand_t            mn3, mx3;
  luma_t            spread, mid;
  logic             draw;
  logic [7:0]       pattern;
  q_entry_t         entry_d;

  // Hold every stage while the last one cannot push
  assign adv        = !d_v_q || !q_full_i;
  assign in_ready_o = adv;
  assign push_o     = d_v_q && !q_full_i;
  assign push_data_o = d_entry_q;

  // Weighted channel sum per pixel
  always_comb begin
    for (int k = 0; k < NumPix; k++) begin
      sum_d[k] = 18'(pix_i[k][23:16]) * LumaR
               + 18'(pix_i[k][15:8])  * LumaG
               + 18'(pix_i[k][7:0])   * LumaB;
    end
  end

  // Scale by the reciprocal of 1000
  always_comb begin
    for (int k = 0; k < NumPix; k++) begin
      prod_d[k] = ProdW'(a_sum_q[k]) * ProdW'(LumaRecip);
      luma_d[k] = prod_d[k][LumaShift+7:LumaShift];
    end
  end

  // Darkest and brightest search as a three-level tree, left wins ties
  always_comb begin
    for (int k = 0; k < NumPix; k++) begin
      leaf[k].v  = b_mask_q[k];
      leaf[k].l  = b_mask_q[k] ? b_luma_q[k] : '0;
      leaf[k].px = b_mask_q[k] ? b_px_q[k]   : '0;
    end
    for (int i = 0; i < 4; i++) begin
      mn1[i] = pick_min(leaf[2*i], leaf[2*i+1]);
      mx1[i] = pick_max(leaf[2*i], leaf[2*i+1]);
    end
    for (int j = 0; j < 2; j++) begin
      mn2[j] = pick_min(mn1[2*j], mn1[2*j+1]);
      mx2[j] = pick_max(mx1[2*j], mx1[2*j+1]);
    end
    mn3 = pick_min(mn2[0], mn2[1]);
    mx3 = pick_max(mx2[0], mx2[1]);
  end

  // Contrast test and dot thresholding
  always_comb begin
    spread  = c_max_q - c_min_q;
    mid     = 8'((9'(c_min_q) + 9'(c_max_q)) >> 1);
    draw    = c_any_q && (spread > floor_i);
    pattern = '0;
    for (int k = 0; k < NumPix; k++) begin
      pattern[DotPos[k]] = draw && c_mask_q[k] && (c_luma_q[k] > mid);
    end
    entry_d.dot_pattern = pattern;
    entry_d.fore        = draw ? c_bright_q : c_dark_q;
    entry_d.back        = c_dark_q;
    entry_d.end_of_row  = c_eor_q;
  end

  // Stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (adv) begin
      a_v_q <= in_valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  // Stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < NumPix; k++) begin
        a_sum_q[k]  <= sum_d[k];
        a_px_q[k]   <= pix_i[k];
        b_luma_q[k] <= luma_d[k];
        b_px_q[k]   <= a_px_q[k];
        c_luma_q[k] <= b_luma_q[k];
      end
      a_mask_q   <= mask_i;
      a_eor_q    <= eor_i;
      b_mask_q   <= a_mask_q;
      b_eor_q    <= a_eor_q;
      c_mask_q   <= b_mask_q;
      c_eor_q    <= b_eor_q;
      c_any_q    <= mn3.v;
      c_min_q    <= mn3.l;
      c_max_q    <= mx3.l;
      c_dark_q   <= mn3.px;
      c_bright_q <= mx3.px;
      d_entry_q  <= entry_d;
    end
  end

endmodule

>>> design/bce_back.sv
// Output stage: previous-colour compare, row state, glyph bytes, output register.
// Depends on bce_pkg; drains bce_fifo.
`timescale 1ns / 1ps

module bce_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bce_pkg::q_status_t q_status_i,
  input  bce_pkg::q_entry_t  q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         dot_pattern_o,
  output logic [7:0]         glyph_mid_byte_o,
  output logic [7:0]         glyph_low_byte_o,
  output bce_pkg::pixel_t    fore_color_o,
  output bce_pkg::pixel_t    back_color_o,
  output logic               fore_changed_o,
  output logic               back_changed_o,
  output logic               row_done_o
);
  import bce_pkg::*;

  logic       out_valid_q;
  pixel_t     last_fore_q, last_back_q;
  logic [7:0] pat_q, mid_q, low_q;
  pixel_t     fore_q, back_q;
  logic       fore_chg_q, back_chg_q, row_done_q;

  // Take a queue entry when the output register is free or being emptied
  assign pop_o = !q_status_i.empty && (!out_valid_q || out_ready_i);

  // Output valid and previous colours of the row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      last_fore_q <= '0;
      last_back_q <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        last_fore_q <= q_data_i.end_of_row ? '0 : q_data_i.fore;
        last_back_q <= q_data_i.end_of_row ? '0 : q_data_i.back;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Load the result transaction
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      pat_q      <= q_data_i.dot_pattern;
      mid_q      <= GlyphMidBase + {6'b0, q_data_i.dot_pattern[7:6]};
      low_q      <= GlyphLowBase + {2'b0, q_data_i.dot_pattern[5:0] & GlyphLowMask};
      fore_q     <= q_data_i.fore;
      back_q     <= q_data_i.back;
      fore_chg_q <= (q_data_i.fore != last_fore_q);
      back_chg_q <= (q_data_i.back != last_back_q);
      row_done_q <= q_data_i.end_of_row;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign dot_pattern_o    = pat_q;
  assign glyph_mid_byte_o = mid_q;
  assign glyph_low_byte_o = low_q;
  assign fore_color_o     = fore_q;
  assign back_color_o     = back_q;
  assign fore_changed_o   = fore_chg_q;
  assign back_changed_o   = back_chg_q;
  assign row_done_o       = row_done_q;

endmodule

>>> sim/tb_braille_cell_encoder.sv
`timescale 1ns / 1ps
// Testbench for braille_cell_encoder: directed and random 2x4 pixel cells, each result
// checked field by field against a luma and row-colour predictor in a scoreboard class.
// Depends on bce_pkg and the braille_cell_encoder RTL; reads no files.

module tb_braille_cell_encoder;
  import bce_pkg::pixel_t;

  localparam int unsigned CycleLimit  = 300000;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned PhaseCells  = 100;
  localparam int unsigned NumPhases   = 6;
  localparam logic [7:0]  FloorAtReset = 8'd25;
  // Dot bit driven by each pixel, Unicode braille order
  localparam int unsigned DotIdx [8] = '{0, 3, 1, 4, 2, 5, 6, 7};

  typedef struct {
    pixel_t     px [8];
    logic [7:0] mask;
    logic       eor;
  } cell_t;

  typedef struct packed {
    logic [7:0] dots;
    logic [7:0] mid_byte;
    logic [7:0] low_byte;
    pixel_t     fore;
    pixel_t     back;
    logic       fore_chg;
    logic       back_chg;
    logic       row_done;
  } glyph_t;

  // Predicts one glyph per accepted cell and checks results in order
  class glyph_scoreboard;
    logic [7:0]  floor_q;
    pixel_t      row_fore;
    pixel_t      row_back;
    glyph_t      expected_glyphs [$];
    int unsigned mismatches;

    function new();
      floor_q    = FloorAtReset;
      row_fore   = '0;
      row_back   = '0;
      mismatches = 0;
    endfunction

    function int unsigned luma(pixel_t p);
      int unsigned r, g, b;
      r = p[23:16];
      g = p[15:8];
      b = p[7:0];
      return (r * 213 + g * 715 + b * 72) / 1000;
    endfunction

    function void note_cell(cell_t c);
      int unsigned lum [8];
      int unsigned lo, hi, mid;
      bit          any;
      pixel_t      dark, bright;
      glyph_t      g;
      any    = 1'b0;
      lo     = 0;
      hi     = 0;
      dark   = '0;
      bright = '0;
      g      = '0;
      // find first darkest and first brightest valid pixel
      for (int k = 0; k < 8; k++) begin
        lum[k] = luma(c.px[k]);
        if (c.mask[k]) begin
          if (!any || lum[k] < lo) begin
            lo   = lum[k];
            dark = c.px[k];
          end
          if (!any || lum[k] > hi) begin
            hi     = lum[k];
            bright = c.px[k];
          end
          any = 1'b1;
        end
      end
      // draw dots above the midpoint only when the spread beats the floor
      if (any && (hi - lo) > floor_q) begin
        mid = (lo + hi) / 2;
        for (int k = 0; k < 8; k++) begin
          if (c.mask[k] && lum[k] > mid) g.dots[DotIdx[k]] = 1'b1;
        end
      end else begin
        bright = dark;
      end
      g.mid_byte = 8'hA0 + g.dots[7:6];
      g.low_byte = 8'h80 + g.dots[5:0];
      g.fore     = bright;
      g.back     = dark;
      g.fore_chg = (bright != row_fore);
      g.back_chg = (dark != row_back);
      g.row_done = c.eor;
      // carry colours along the row, back to black after its last cell
      if (c.eor) begin
        row_fore = '0;
        row_back = '0;
      end else begin
        row_fore = bright;
        row_back = dark;
      end
      expected_glyphs.push_back(g);
    endfunction

    task report(string what, int unsigned got, int unsigned want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_glyph(glyph_t got);
      glyph_t want;
      if (expected_glyphs.size() == 0) begin
        report("unrequested glyph", got.dots, 0);
        return;
      end
      want = expected_glyphs.pop_front();
      if (got.dots !== want.dots) report("dot_pattern", got.dots, want.dots);
      if (got.mid_byte !== want.mid_byte) report("glyph_mid_byte", got.mid_byte, want.mid_byte);
      if (got.low_byte !== want.low_byte) report("glyph_low_byte", got.low_byte, want.low_byte);
      if (got.fore !== want.fore) report("fore_color", got.fore, want.fore);
      if (got.back !== want.back) report("back_color", got.back, want.back);
      if (got.fore_chg !== want.fore_chg) report("fore_changed", got.fore_chg, want.fore_chg);
      if (got.back_chg !== want.back_chg) report("back_changed", got.back_chg, want.back_chg);
      if (got.row_done !== want.row_done) report("row_done", got.row_done, want.row_done);
    endtask
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  pixel_t     pixel_0_i, pixel_1_i, pixel_2_i, pixel_3_i;
  pixel_t     pixel_4_i, pixel_5_i, pixel_6_i, pixel_7_i;
  logic [7:0] valid_mask_i;
  logic       end_of_row_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] dot_pattern_o;
  logic [7:0] glyph_mid_byte_o;
  logic [7:0] glyph_low_byte_o;
  pixel_t     fore_color_o;
  pixel_t     back_color_o;
  logic       fore_changed_o;
  logic       back_changed_o;
  logic       row_done_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;

  glyph_scoreboard sb;
  cell_t           last_cell;
  int unsigned     send_idle_pct  = 0;
  int unsigned     recv_stall_pct = 0;
  int unsigned     hold_left      = 0;
  int unsigned     cycles         = 0;

  braille_cell_encoder u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .pixel_0_i        (pixel_0_i),
    .pixel_1_i        (pixel_1_i),
    .pixel_2_i        (pixel_2_i),
    .pixel_3_i        (pixel_3_i),
    .pixel_4_i        (pixel_4_i),
    .pixel_5_i        (pixel_5_i),
    .pixel_6_i        (pixel_6_i),
    .pixel_7_i        (pixel_7_i),
    .valid_mask_i     (valid_mask_i),
    .end_of_row_i     (end_of_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .dot_pattern_o    (dot_pattern_o),
    .glyph_mid_byte_o (glyph_mid_byte_o),
    .glyph_low_byte_o (glyph_low_byte_o),
    .fore_color_o     (fore_color_o),
    .back_color_o     (back_color_o),
    .fore_changed_o   (fore_changed_o),
    .back_changed_o   (back_changed_o),
    .row_done_o       (row_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Count down a long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Check each result transaction, then pick the next ready value
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_glyph({dot_pattern_o, glyph_mid_byte_o, glyph_low_byte_o, fore_color_o,
                      back_color_o, fore_changed_o, back_changed_o, row_done_o});
    end
    out_ready_i <= rst_ni && (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic pixel_t grey(logic [7:0] v);
    return {v, v, v};
  endfunction

  function automatic cell_t filled(pixel_t p);
    cell_t c;
    for (int k = 0; k < 8; k++) c.px[k] = p;
    c.mask = 8'hFF;
    c.eor  = 1'b0;
    return c;
  endfunction

  // Mostly two-colour, repeated and near-floor cells; the rest pure noise
  function automatic cell_t random_cell();
    cell_t       c;
    pixel_t      a, b;
    int unsigned kind, base;
    kind = $urandom_range(99);
    a    = pixel_t'($urandom);
    b    = pixel_t'($urandom);
    base = $urandom_range(210);
    if ($urandom_range(30) == 0) c.mask = 8'h00;
    else if ($urandom_range(4) == 0) c.mask = 8'($urandom);
    else c.mask = 8'hFF;
    c.eor = ($urandom_range(7) == 0);
    for (int k = 0; k < 8; k++) begin
      if (kind < 35) c.px[k] = $urandom_range(1) ? a : b;
      else if (kind < 60) c.px[k] = pixel_t'($urandom);
      else if (kind < 75) c.px[k] = last_cell.px[k];
      else c.px[k] = grey(8'(base + $urandom_range(45)));
    end
    if (kind >= 60 && kind < 75) c.mask = last_cell.mask;
    return c;
  endfunction

  task automatic push_cell(cell_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_0_i    <= c.px[0];
    pixel_1_i    <= c.px[1];
    pixel_2_i    <= c.px[2];
    pixel_3_i    <= c.px[3];
    pixel_4_i    <= c.px[4];
    pixel_5_i    <= c.px[5];
    pixel_6_i    <= c.px[6];
    pixel_7_i    <= c.px[7];
    valid_mask_i <= c.mask;
    end_of_row_i <= c.eor;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_cell(c);
    last_cell = c;
  endtask

  task automatic write_floor(logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.floor_q = v;
  endtask

  task automatic wait_drained();
    while (sb.expected_glyphs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_directed();
    cell_t c;
    // flat black and flat white
    c = filled('0);
    push_cell(c);
    c = filled(24'hFFFFFF);
    push_cell(c);
    // checkerboard both ways round
    for (int k = 0; k < 8; k++) c.px[k] = (k % 2 == 0) ? 24'hFFFFFF : 24'h000000;
    push_cell(c);
    for (int k = 0; k < 8; k++) c.px[k] = ~c.px[k];
    push_cell(c);
    // no valid pixel, then only the last one valid
    for (int k = 0; k < 8; k++) c.px[k] = pixel_t'($urandom);
    c.mask = 8'h00;
    push_cell(c);
    c.mask = 8'h80;
    push_cell(c);
    // bright pixels outside the image must be ignored
    c = filled(24'hFFFFFF);
    for (int k = 0; k < 4; k++) c.px[k] = grey(8'(k * 10));
    c.mask = 8'h0F;
    push_cell(c);
    // spread equal to the floor draws nothing, one more draws
    c = filled(grey(100));
    c.px[5] = grey(125);
    push_cell(c);
    c.px[5] = grey(126);
    push_cell(c);
    // luma on the midpoint gets no dot
    c = filled(grey(100));
    c.px[1] = grey(200);
    c.px[6] = grey(150);
    c.px[7] = grey(151);
    push_cell(c);
    // ties on least luma: the first one is the background
    c = filled(grey(180));
    c.px[2] = 24'h010000;
    c.px[4] = 24'h000000;
    push_cell(c);
    // ties on greatest luma: the first one is the foreground
    c = filled('0);
    c.px[3] = 24'hFF0000;
    c.px[6] = grey(54);
    push_cell(c);
    // one lit dot at each position
    for (int k = 0; k < 8; k++) begin
      c = filled('0);
      c.px[k] = 24'hFFFFFF;
      push_cell(c);
    end
    // colours repeat within a row, then start over after its end
    c = filled(24'h123456);
    c.px[0] = 24'hFEDCBA;
    push_cell(c);
    push_cell(c);
    c.eor = 1'b1;
    push_cell(c);
    c.eor = 1'b0;
    push_cell(c);
  endtask

  initial begin
    logic [7:0] floor_v;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    pixel_0_i    = '0;
    pixel_1_i    = '0;
    pixel_2_i    = '0;
    pixel_3_i    = '0;
    pixel_4_i    = '0;
    pixel_5_i    = '0;
    pixel_6_i    = '0;
    pixel_7_i    = '0;
    valid_mask_i = '0;
    end_of_row_i = 1'b0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed cells run on the floor left by reset
    run_directed();
    in_valid_i <= 1'b0;
    wait_drained();

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       floor_v = 8'd0;
        1:       floor_v = 8'd255;
        2:       floor_v = 8'($urandom_range(254, 1));
        3:       floor_v = FloorAtReset;
        4:       floor_v = 8'd1;
        default: floor_v = 8'd254;
      endcase
      write_floor(floor_v);
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 84;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 84;
        end
        default: begin
          send_idle_pct  = 24;
          recv_stall_pct = 24;
        end
      endcase
      // hold the receiver off while cells keep coming, to back up the queue
      if (p % 4 == 0) hold_left <= HoldCycles;
      for (int n = 0; n < PhaseCells; n++) push_cell(random_cell());
      in_valid_i <= 1'b0;
      wait_drained();
    end

    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/bce_pkg.sv
design/bce_fifo.sv
design/bce_front.sv
design/bce_back.sv
design/braille_cell_encoder.sv
sim/tb_braille_cell_encoder.sv
